// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while in reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that is also checked during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/tpbb_pkg.sv =====
// types, constants and arithmetic helpers for the transformed point bounding box
package tpbb_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int EFF_WIDTH   = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
    localparam int POS_W       = 32;
    localparam int COEF_W      = 16;
    localparam int ROW_W       = 3 * COEF_W;
    localparam int PROD_W      = POS_W + COEF_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int FRAC_SHIFT  = 14;
    localparam int RND_W       = SUM_W - FRAC_SHIFT;
    localparam int LOC_W       = RND_W + 2;
    localparam int CFG_IDX_W   = 3;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_SHIFT - 1);
    localparam logic signed [LOC_W-1:0] SAT_MAX =
        (LOC_W'(1) <<< (EFF_WIDTH - 1)) - LOC_W'(1);
    localparam logic signed [LOC_W-1:0] SAT_MIN = -(LOC_W'(1) <<< (EFF_WIDTH - 1));

    localparam logic [ROW_W-1:0] ROT_ROW_X_RST = ROW_W'(48'h0000_0000_4000);
    localparam logic [ROW_W-1:0] ROT_ROW_Y_RST = ROW_W'(48'h0000_4000_0000);
    localparam logic [ROW_W-1:0] ROT_ROW_Z_RST = ROW_W'(48'h4000_0000_0000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_ROW_X = 3'd0,
        REG_ROT_ROW_Y = 3'd1,
        REG_ROT_ROW_Z = 3'd2,
        REG_SHIFT_X   = 3'd3,
        REG_SHIFT_Y   = 3'd4,
        REG_SHIFT_Z   = 3'd5
    } cfg_reg_t;

    typedef logic signed [POS_W-1:0]  coord_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic                    last_vertex;
    } vtx_beat_t;

    typedef struct packed {
        logic signed [POS_W-1:0] min_x;
        logic signed [POS_W-1:0] min_y;
        logic signed [POS_W-1:0] min_z;
        logic signed [POS_W-1:0] max_x;
        logic signed [POS_W-1:0] max_y;
        logic signed [POS_W-1:0] max_z;
    } box_beat_t;

    // frame configuration as seen by the datapath
    typedef struct packed {
        logic [2:0][ROW_W-1:0] rot;
        coord_t [2:0]          shift;
    } frame_t;

    // one transformed point heading for the box stage
    typedef struct packed {
        coord_t [2:0] c;
        logic         last;
    } point_t;

    function automatic logic signed [COEF_W-1:0] coef(input logic [ROW_W-1:0] row,
                                                      input logic [1:0] k);
        logic signed [COEF_W-1:0] c;
        c = '0;
        case (k)
            2'd0:    c = row[COEF_W-1:0];
            2'd1:    c = row[2*COEF_W-1:COEF_W];
            2'd2:    c = row[3*COEF_W-1:2*COEF_W];
            default: c = '0;
        endcase
        return c;
    endfunction

    // sum of three Q18.30 products, round half up to Q16.16, add shift, clamp
    function automatic coord_t sat_coord(input prod_t p0, input prod_t p1, input prod_t p2,
                                         input coord_t sh);
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] r;
        logic signed [LOC_W-1:0] loc;
        logic signed [LOC_W-1:0] clamped;
        s = SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2) + ROUND_HALF;
        r = s >>> FRAC_SHIFT;
        loc = LOC_W'($signed(r[RND_W-1:0])) + LOC_W'(sh);
        if (loc > SAT_MAX)
        begin
            clamped = SAT_MAX;
        end
        else if (loc < SAT_MIN)
        begin
            clamped = SAT_MIN;
        end
        else
        begin
            clamped = loc;
        end
        return clamped[POS_W-1:0];
    endfunction

endpackage

// ===== rtl/core/transformed_point_bounding_box.sv =====
// a last vertex goes via vertex, product, coordinate registers to the result register
// throughput: one vertex per cycle unless stalled, three register transform pipeline
// a box beat waiting at the output stalls only the next last vertex, at the box stage
// reset: pipeline and result empty, box cleared, rotation identity, translation zero
// configuration writes are always taken and apply to beats processed afterwards
module transformed_point_bounding_box import tpbb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ROW_W-1:0]     cfg_data,
    input  logic                 vtx_valid,
    output logic                 vtx_ready,
    input  vtx_beat_t            vtx,
    output logic                 box_valid,
    input  logic                 box_ready,
    output box_beat_t            box
);

    `include "assert_macros.svh"

    frame_t frame_reg;
    logic   pt_valid;
    logic   pt_ready;
    point_t pt;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg.rot[0] <= ROT_ROW_X_RST;
            frame_reg.rot[1] <= ROT_ROW_Y_RST;
            frame_reg.rot[2] <= ROT_ROW_Z_RST;
            frame_reg.shift  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ROT_ROW_X: frame_reg.rot[0]   <= cfg_data;
                REG_ROT_ROW_Y: frame_reg.rot[1]   <= cfg_data;
                REG_ROT_ROW_Z: frame_reg.rot[2]   <= cfg_data;
                REG_SHIFT_X:   frame_reg.shift[0] <= cfg_data[POS_W-1:0];
                REG_SHIFT_Y:   frame_reg.shift[1] <= cfg_data[POS_W-1:0];
                REG_SHIFT_Z:   frame_reg.shift[2] <= cfg_data[POS_W-1:0];
                default:       ;
            endcase
        end
    end

    tpbb_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame_reg),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .vtx       (vtx),
        .pt_valid  (pt_valid),
        .pt_ready  (pt_ready),
        .pt        (pt)
    );

    tpbb_box u_box (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt_valid  (pt_valid),
        .pt_ready  (pt_ready),
        .pt        (pt),
        .box_valid (box_valid),
        .box_ready (box_ready),
        .box       (box)
    );

    // inner vertices never stall at the box stage
    `ASSERT_CLK(a_inner_no_stall, clk, rst_n, pt_valid && !pt.last |-> pt_ready, "inner vertex stalled")
    // a closing vertex waits only on a full result register
    `ASSERT_CLK(a_last_stall_cause, clk, rst_n, pt_valid && !pt_ready |-> box_valid && !box_ready, "box stage stalled without cause")
    // a rise of box_valid comes from a closing vertex taken the cycle before
    `ASSERT_CLK(a_result_source, clk, rst_n, $rose(box_valid) |-> $past(pt_valid && pt_ready && pt.last), "result beat without last vertex")

endmodule

// ===== rtl/core/tpbb_xform.sv =====
// three stage transform: vertex register, product register, rounded coordinate register
module tpbb_xform import tpbb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  frame_t    frame,
    input  logic      vtx_valid,
    output logic      vtx_ready,
    input  vtx_beat_t vtx,
    output logic      pt_valid,
    input  logic      pt_ready,
    output point_t    pt
);

    logic      v1_reg, v2_reg, v3_reg;
    logic      r1, r2, r3;
    coord_t [2:0] pos_reg;
    logic      last1_reg, last2_reg;
    prod_t [2:0][2:0] prod_reg;
    prod_t [2:0][2:0] prod_next;
    point_t    pt_reg;
    point_t    pt_next;

    // each stage takes a beat when it is empty or its beat moves on
    assign r3 = !v3_reg || pt_ready;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign vtx_ready = r1;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_next[a][k] = PROD_W'(coef(frame.rot[a], 2'(k))) * PROD_W'(pos_reg[k]);
            end
        end
    end

    always_comb
    begin
        pt_next.last = last2_reg;
        for (int a = 0; a < 3; a++)
        begin
            pt_next.c[a] = sat_coord(prod_reg[a][0], prod_reg[a][1], prod_reg[a][2],
                                     frame.shift[a]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= vtx_valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && vtx_valid)
        begin
            pos_reg[0] <= vtx.pos_x;
            pos_reg[1] <= vtx.pos_y;
            pos_reg[2] <= vtx.pos_z;
            last1_reg  <= vtx.last_vertex;
        end
        if (r2 && v1_reg)
        begin
            prod_reg  <= prod_next;
            last2_reg <= last1_reg;
        end
        if (r3 && v2_reg)
        begin
            pt_reg <= pt_next;
        end
    end

    assign pt_valid = v3_reg;
    assign pt       = pt_reg;

endmodule

// ===== rtl/core/tpbb_box.sv =====
// running per-axis minima and maxima with the result register
module tpbb_box import tpbb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pt_valid,
    output logic      pt_ready,
    input  point_t    pt,
    output logic      box_valid,
    input  logic      box_ready,
    output box_beat_t box
);

    coord_t [2:0] low_reg, high_reg;
    coord_t [2:0] low_next, high_next;
    logic         started_reg;
    logic         box_valid_reg;
    box_beat_t    box_reg;
    logic         take;

    // only a closing beat needs the result register to be free
    assign pt_ready = !pt.last || !box_valid_reg || box_ready;
    assign take     = pt_valid && pt_ready;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            low_next[a]  = (!started_reg || pt.c[a] < low_reg[a])  ? pt.c[a] : low_reg[a];
            high_next[a] = (!started_reg || pt.c[a] > high_reg[a]) ? pt.c[a] : high_reg[a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            box_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                started_reg <= !pt.last;
            end
            if (take && pt.last)
            begin
                box_valid_reg <= 1'b1;
            end
            else if (box_ready)
            begin
                box_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
        if (take && pt.last)
        begin
            box_reg.min_x <= low_next[0];
            box_reg.min_y <= low_next[1];
            box_reg.min_z <= low_next[2];
            box_reg.max_x <= high_next[0];
            box_reg.max_y <= high_next[1];
            box_reg.max_z <= high_next[2];
        end
    end

    assign box_valid = box_valid_reg;
    assign box       = box_reg;

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for the transformed point bounding box: vertex driver, box monitor, box predictor
module testbench;
    import tpbb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam int DRAIN_CYCLES = 8;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ROW_W-1:0]     cfg_data = '0;
    logic                 vtx_valid = 1'b0;
    logic                 vtx_ready;
    vtx_beat_t            vtx = '0;
    logic                 box_valid;
    logic                 box_ready = 1'b0;
    box_beat_t            box;

    transformed_point_bounding_box dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .vtx       (vtx),
        .box_valid (box_valid),
        .box_ready (box_ready),
        .box       (box)
    );

    always #4 clk = ~clk;

    // frame copy and running box of the predictor
    logic [ROW_W-1:0] frame_rot [3] = '{ROT_ROW_X_RST, ROT_ROW_Y_RST, ROT_ROW_Z_RST};
    coord_t           frame_shift [3] = '{32'sd0, 32'sd0, 32'sd0};
    coord_t           run_low [3];
    coord_t           run_high [3];
    bit               run_open = 1'b0;

    vtx_beat_t vtx_pending [$];
    box_beat_t boxes_due [$];
    int        vtx_queued = 0;
    int        vtx_taken = 0;
    int        vtx_gap = 0;
    int        box_gap = 0;
    int        err_count = 0;
    bit        idle_on = 1'b1;

    function automatic coord_t frame_coord(logic [ROW_W-1:0] row, coord_t sh, coord_t px,
                                           coord_t py, coord_t pz);
        longint acc;
        longint lim_hi;
        longint lim_lo;
        lim_hi = (64'sd1 <<< (EFF_WIDTH - 1)) - 1;
        lim_lo = -(64'sd1 <<< (EFF_WIDTH - 1));
        acc = longint'($signed(row[15:0])) * longint'(px)
            + longint'($signed(row[31:16])) * longint'(py)
            + longint'($signed(row[47:32])) * longint'(pz);
        // round half toward plus infinity, then back to q16.16
        acc = ((acc + 64'sd8192) >>> FRAC_SHIFT) + longint'(sh);
        if (acc > lim_hi)
            acc = lim_hi;
        if (acc < lim_lo)
            acc = lim_lo;
        return coord_t'(acc);
    endfunction

    function automatic void fold_vertex(vtx_beat_t v);
        coord_t    loc [3];
        box_beat_t b;
        int        k;
        for (k = 0; k < 3; k++)
        begin
            loc[k] = frame_coord(frame_rot[k], frame_shift[k], v.pos_x, v.pos_y, v.pos_z);
            if (!run_open || loc[k] < run_low[k])
                run_low[k] = loc[k];
            if (!run_open || loc[k] > run_high[k])
                run_high[k] = loc[k];
        end
        run_open = 1'b1;
        if (v.last_vertex)
        begin
            b.min_x = run_low[0];
            b.min_y = run_low[1];
            b.min_z = run_low[2];
            b.max_x = run_high[0];
            b.max_y = run_high[1];
            b.max_z = run_high[2];
            boxes_due.push_back(b);
            run_open = 1'b0;
        end
    endfunction

    function automatic void frame_apply(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
        case (idx)
            REG_ROT_ROW_X: frame_rot[0] = data;
            REG_ROT_ROW_Y: frame_rot[1] = data;
            REG_ROT_ROW_Z: frame_rot[2] = data;
            REG_SHIFT_X:   frame_shift[0] = data[POS_W-1:0];
            REG_SHIFT_Y:   frame_shift[1] = data[POS_W-1:0];
            REG_SHIFT_Z:   frame_shift[2] = data[POS_W-1:0];
            default:       ;
        endcase
    endfunction

    function automatic void check_field(string name, coord_t want, coord_t got);
        if (want !== got)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            err_count++;
        end
    endfunction

    function automatic void queue_vertex(coord_t x, coord_t y, coord_t z, bit last);
        vtx_beat_t v;
        v.pos_x = x;
        v.pos_y = y;
        v.pos_z = z;
        v.last_vertex = last;
        vtx_pending.push_back(v);
        vtx_queued++;
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return coord_t'($urandom_range(0, 262143)) - 32'sd131072;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 9))
            0:       return 16'h4000;
            1:       return 16'hC000;
            2:       return 16'h0000;
            3:       return 16'h7FFF;
            4:       return 16'h8000;
            5:       return 16'h2D41;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic coord_t rand_shift();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sd0;
            3, 4:    return coord_t'($urandom_range(0, 2097151)) - 32'sd1048576;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic void queue_mesh(int n, bit close);
        int i;
        for (i = 0; i < n; i++)
            queue_vertex(rand_coord(), rand_coord(), rand_coord(), close && (i == n - 1));
    endfunction

    // called at a rising edge; leaves cfg_valid high for a following write
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        frame_apply(idx, data);
    endtask

    task automatic cfg_done();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(logic [ROW_W-1:0] rx, logic [ROW_W-1:0] ry, logic [ROW_W-1:0] rz,
                             logic [ROW_W-1:0] sx, logic [ROW_W-1:0] sy, logic [ROW_W-1:0] sz);
        cfg_write(REG_ROT_ROW_X, rx);
        cfg_write(REG_ROT_ROW_Y, ry);
        cfg_write(REG_ROT_ROW_Z, rz);
        cfg_write(REG_SHIFT_X, sx);
        cfg_write(REG_SHIFT_Y, sy);
        cfg_write(REG_SHIFT_Z, sz);
    endtask

    task automatic random_frame();
        cfg_reg_t rows [3];
        cfg_reg_t shifts [3];
        int       i;
        rows = '{REG_ROT_ROW_X, REG_ROT_ROW_Y, REG_ROT_ROW_Z};
        shifts = '{REG_SHIFT_X, REG_SHIFT_Y, REG_SHIFT_Z};
        for (i = 0; i < 3; i++)
            if ($urandom_range(0, 3) != 0)
                cfg_write(rows[i], {rand_coef(), rand_coef(), rand_coef()});
        for (i = 0; i < 3; i++)
            if ($urandom_range(0, 3) != 0)
                cfg_write(shifts[i], {16'($urandom), rand_shift()});
        if ($urandom_range(0, 3) == 0)
            cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 48'($urandom));
        cfg_done();
    endtask

    // sender holds off until every box has come back and the pipeline is empty
    task automatic drain();
        @(posedge clk);
        while (vtx_taken != vtx_queued || boxes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : vtx_driver
        bit go;
        if (rst_n)
        begin
            if (vtx_valid && vtx_ready)
            begin
                fold_vertex(vtx);
                vtx_taken++;
            end
            if (!vtx_valid || vtx_ready)
            begin
                go = 1'b0;
                if (vtx_gap > 0)
                    vtx_gap--;
                else if (vtx_pending.size() > 0)
                begin
                    if (idle_on && $urandom_range(0, 9) == 0)
                        vtx_gap = $urandom_range(0, 8);
                    else
                        go = 1'b1;
                end
                if (go)
                    vtx <= vtx_pending.pop_front();
                vtx_valid <= go;
            end
        end
    end

    always @(posedge clk)
    begin : box_monitor
        box_beat_t want;
        if (rst_n)
        begin
            if (box_valid && box_ready)
            begin
                if (boxes_due.size() == 0)
                begin
                    $error("box beat with no box expected");
                    err_count++;
                end
                else
                begin
                    want = boxes_due.pop_front();
                    check_field("min_x", want.min_x, box.min_x);
                    check_field("min_y", want.min_y, box.min_y);
                    check_field("min_z", want.min_z, box.min_z);
                    check_field("max_x", want.max_x, box.max_x);
                    check_field("max_y", want.max_y, box.max_y);
                    check_field("max_z", want.max_z, box.max_z);
                end
            end
            if (box_gap > 0)
            begin
                box_gap--;
                box_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                box_gap = $urandom_range(0, 8);
                box_ready <= 1'b0;
            end
            else
            begin
                box_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

    initial
    begin : stimulus
        int ph;
        int n;
        int len;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity frame from reset
        queue_vertex(32'sd0, 32'sd0, 32'sd0, 1'b1);
        queue_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1, 1'b0);
        queue_vertex(32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1, 1'b0);
        queue_vertex(32'sh1234_5678, -32'sd4660, 32'sd0, 1'b1);
        queue_vertex(-32'sd1, -32'sd1, -32'sd1, 1'b1);
        drain();

        // tiny x and y coefficients expose rounding ties in both signs
        set_frame(48'h0000_0000_0001, 48'h0000_0000_FFFF, 48'h8000_7FFF_0001,
                  48'h0000_0000_0000, 48'h0000_0000_0000, 48'hFFFF_0000_0000);
        cfg_write(REG_SPARE_A, 48'hFFFF_FFFF_FFFF);
        cfg_write(REG_SPARE_B, 48'h1234_5678_9ABC);
        cfg_done();
        queue_vertex(32'sd8192, 32'sd0, 32'sd0, 1'b1);
        queue_vertex(-32'sd8192, 32'sd0, 32'sd0, 1'b1);
        queue_vertex(32'sd24576, 32'sd8192, -32'sd8192, 1'b1);
        queue_vertex(-32'sd24576, -32'sd8192, 32'sd8191, 1'b1);
        drain();

        // largest positive coefficients and shifts, upper data bits set
        set_frame(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
                  48'hFFFF_7FFF_FFFF, 48'hA5A5_7FFF_FFFF, 48'h0000_7FFF_FFFF);
        cfg_done();
        queue_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
        queue_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
        queue_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 1'b1);
        drain();

        // most negative coefficients and shifts
        set_frame(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                  48'h0000_8000_0000, 48'hFFFF_8000_0000, 48'h5A5A_8000_0000);
        cfg_done();
        queue_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        queue_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
        queue_vertex(32'sd0, 32'sd0, 32'sd0, 1'b1);
        drain();

        for (ph = 0; ph < 6; ph++)
        begin
            if (ph == 5)
                idle_on = 1'b0;
            random_frame();
            n = 0;
            while (n < 265)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                queue_mesh(len, 1'b1);
                n += len;
            end
            // an open mesh carried across a frame change
            if (ph < 5 && $urandom_range(0, 1) == 1)
                queue_mesh($urandom_range(1, 4), 1'b0);
            drain();
        end

        if (err_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
